@@ src/rsp_pkg.sv @@
// Shared types and codes for the RGB565 sprite pixel blender.
// Used by every stage module and the top level.
package rsp_pkg;

    localparam logic [1:0] FMT_KEYED    = 2'd0;
    localparam logic [1:0] FMT_ARGB1555 = 2'd1;
    localparam logic [1:0] FMT_BGRA8888 = 2'd2;

    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_ALPHA   = 2'd2;

    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_BLEND_MODE    = 2'd1;
    localparam logic [1:0] REG_ALPHA_LEVEL   = 2'd2;
    localparam logic [1:0] REG_COLOR_KEY     = 2'd3;

    localparam logic [5:0] FULL_WEIGHT = 6'd32;
    localparam logic [4:0] MAX5        = 5'h1F;
    localparam logic [5:0] MAX6        = 6'h3F;

    typedef struct packed {
        logic [1:0]  source_format;
        logic [1:0]  blend_mode;
        logic [5:0]  alpha_level;
        logic [15:0] color_key;
    } cfg_t;

    typedef struct packed {
        logic [15:0] s565;
        logic [15:0] dst;
        logic        opaque;
    } conv_t;

    typedef struct packed {
        logic [15:0] s565;
        logic [15:0] dst;
        logic        opaque;
        logic [1:0]  mode;
        logic [15:0] add_pix;
        logic [9:0]  rs_w;
        logic [9:0]  rd_w;
        logic [9:0]  bs_w;
        logic [9:0]  bd_w;
        logic [10:0] gs_w;
        logic [10:0] gd_w;
    } prod_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        we;
    } res_t;

endpackage

@@ src/rsp_conv.sv @@
// Stage 1: converts the source pixel to RGB565 and decides transparency.
// Depends on rsp_pkg.
module rsp_conv
(
    input  logic          clk,
    input  logic          rst_n,
    input  rsp_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  logic [31:0]   src_pixel,
    input  logic [15:0]   dst_pixel,
    input  logic          next_ready,
    output logic          ready,
    output logic          valid,
    output rsp_pkg::conv_t data
);

    logic           valid_reg;
    rsp_pkg::conv_t data_reg;
    rsp_pkg::conv_t data_next;

    assign ready = !valid_reg || next_ready;

    always_comb
    begin
        data_next.dst = dst_pixel;
        case (cfg.source_format)
            rsp_pkg::FMT_ARGB1555:
            begin
                data_next.opaque = src_pixel[15];
                data_next.s565   = {src_pixel[14:10], src_pixel[9:5], 1'b0, src_pixel[4:0]};
            end
            rsp_pkg::FMT_BGRA8888:
            begin
                data_next.opaque = (src_pixel[31:24] != 8'd0);
                data_next.s565   = {src_pixel[23:19], src_pixel[15:10], src_pixel[7:3]};
            end
            default:
            begin
                data_next.opaque = (src_pixel[15:0] != cfg.color_key);
                data_next.s565   = src_pixel[15:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ src/rsp_mul.sv @@
// Stage 2: weights each channel for the alpha blend and forms the saturating sum.
// Depends on rsp_pkg.
module rsp_mul
(
    input  logic           clk,
    input  logic           rst_n,
    input  rsp_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  rsp_pkg::conv_t in_data,
    input  logic           next_ready,
    output logic           ready,
    output logic           valid,
    output rsp_pkg::prod_t data
);

    logic           valid_reg;
    rsp_pkg::prod_t data_reg;
    rsp_pkg::prod_t data_next;
    logic [5:0]     a_w;
    logic [5:0]     inv_w;
    logic [5:0]     r_sum;
    logic [6:0]     g_sum;
    logic [5:0]     b_sum;

    assign ready = !valid_reg || next_ready;

    assign a_w   = (cfg.alpha_level > rsp_pkg::FULL_WEIGHT) ? rsp_pkg::FULL_WEIGHT
                                                           : cfg.alpha_level;
    assign inv_w = rsp_pkg::FULL_WEIGHT - a_w;

    assign r_sum = {1'b0, in_data.s565[15:11]} + {1'b0, in_data.dst[15:11]};
    assign g_sum = {1'b0, in_data.s565[10:5]}  + {1'b0, in_data.dst[10:5]};
    assign b_sum = {1'b0, in_data.s565[4:0]}   + {1'b0, in_data.dst[4:0]};

    always_comb
    begin
        data_next.s565    = in_data.s565;
        data_next.dst     = in_data.dst;
        data_next.opaque  = in_data.opaque;
        data_next.mode    = cfg.blend_mode;
        data_next.add_pix = {r_sum[5] ? rsp_pkg::MAX5 : r_sum[4:0],
                             g_sum[6] ? rsp_pkg::MAX6 : g_sum[5:0],
                             b_sum[5] ? rsp_pkg::MAX5 : b_sum[4:0]};
        data_next.rs_w    = 10'(a_w * in_data.s565[15:11]);
        data_next.rd_w    = 10'(inv_w * in_data.dst[15:11]);
        data_next.bs_w    = 10'(a_w * in_data.s565[4:0]);
        data_next.bd_w    = 10'(inv_w * in_data.dst[4:0]);
        data_next.gs_w    = 11'(a_w * in_data.s565[10:5]);
        data_next.gd_w    = 11'(inv_w * in_data.dst[10:5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ src/rsp_mix.sv @@
// Stage 3: sums the weighted channels and selects the result; holds the output beat.
// Depends on rsp_pkg.
module rsp_mix
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rsp_pkg::prod_t in_data,
    input  logic           next_ready,
    output logic           ready,
    output logic           valid,
    output rsp_pkg::res_t  data
);

    logic          valid_reg;
    rsp_pkg::res_t data_reg;
    rsp_pkg::res_t data_next;
    logic [5:0]    r_mix;
    logic [5:0]    b_mix;
    logic [16:0]   rb_mix;
    logic [11:0]   g_mix;
    logic [15:0]   alpha_pix;

    assign ready = !valid_reg || next_ready;

    assign r_mix     = {1'b0, in_data.rs_w[9:5]} + {1'b0, in_data.rd_w[9:5]};
    assign b_mix     = {1'b0, in_data.bs_w[9:5]} + {1'b0, in_data.bd_w[9:5]};
    assign rb_mix    = {r_mix, 11'd0} + {11'd0, b_mix};
    assign g_mix     = {1'b0, in_data.gs_w} + {1'b0, in_data.gd_w};
    assign alpha_pix = rb_mix[15:0] | {5'd0, g_mix[10:5], 5'd0};

    always_comb
    begin
        data_next.we = in_data.opaque;
        if (!in_data.opaque)
        begin
            data_next.pixel = in_data.dst;
        end
        else
        begin
            case (in_data.mode)
                rsp_pkg::MODE_ADD:   data_next.pixel = in_data.add_pix;
                rsp_pkg::MODE_ALPHA: data_next.pixel = alpha_pix;
                default:             data_next.pixel = in_data.s565;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ src/rgb565_sprite_pixel_blender.sv @@
// Top level of the RGB565 sprite pixel blender: configuration registers and three stages.
// Depends on rsp_pkg, rsp_conv, rsp_mul and rsp_mix.
//
//   channel | signals                                       | beat moves when
//   --------+-----------------------------------------------+---------------------------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data        | cfg_valid && cfg_ready
//   pix     | pix_valid pix_ready src_pixel dst_pixel       | pix_valid && pix_ready
//   res     | res_valid res_ready out_pixel write_enable    | res_valid && res_ready
//
// Each beat is registered by rsp_conv, rsp_mul, rsp_mix; one pixel per cycle while not stalled.
// Stages: format convert, channel weighting multiplies, sum and select into the output register.
// Each stage advances when it is empty or the stage after it advances; a stall holds every beat.
// Reset empties the pipeline and loads the register defaults; cfg_ready is always high.
module rgb565_sprite_pixel_blender
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic [31:0] src_pixel,
    input  logic [15:0] dst_pixel,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [15:0] out_pixel,
    output logic        write_enable
);

    rsp_pkg::cfg_t  cfg_reg;
    rsp_pkg::conv_t conv_data;
    rsp_pkg::prod_t prod_data;
    rsp_pkg::res_t  res_data;
    logic           conv_valid;
    logic           prod_valid;
    logic           mul_ready;
    logic           mix_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= rsp_pkg::FMT_KEYED;
            cfg_reg.blend_mode    <= rsp_pkg::MODE_REPLACE;
            cfg_reg.alpha_level   <= rsp_pkg::FULL_WEIGHT;
            cfg_reg.color_key     <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rsp_pkg::REG_SOURCE_FORMAT: cfg_reg.source_format <= cfg_data[1:0];
                rsp_pkg::REG_BLEND_MODE:    cfg_reg.blend_mode    <= cfg_data[1:0];
                rsp_pkg::REG_ALPHA_LEVEL:   cfg_reg.alpha_level   <= cfg_data[5:0];
                rsp_pkg::REG_COLOR_KEY:     cfg_reg.color_key     <= cfg_data;
                default:                    cfg_reg.color_key     <= cfg_reg.color_key;
            endcase
        end
    end

    rsp_conv u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (pix_valid),
        .src_pixel  (src_pixel),
        .dst_pixel  (dst_pixel),
        .next_ready (mul_ready),
        .ready      (pix_ready),
        .valid      (conv_valid),
        .data       (conv_data)
    );

    rsp_mul u_mul
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (conv_valid),
        .in_data    (conv_data),
        .next_ready (mix_ready),
        .ready      (mul_ready),
        .valid      (prod_valid),
        .data       (prod_data)
    );

    rsp_mix u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prod_valid),
        .in_data    (prod_data),
        .next_ready (res_ready),
        .ready      (mix_ready),
        .valid      (res_valid),
        .data       (res_data)
    );

    assign out_pixel    = res_data.pixel;
    assign write_enable = res_data.we;

endmodule

@@ src/rsp_check.sv @@
// Port-level checker for the RGB565 sprite pixel blender, bound to the top level.
// Depends only on the top level's ports.
module rsp_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] out_pixel,
    input logic        write_enable
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_pixel) && $stable(write_enable))
        else $error("result beat changed while stalled");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("input blocked without an output stall");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready ##1 res_ready ##1 res_ready) |=> res_valid)
        else $error("result missing three cycles after an unstalled beat");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind rgb565_sprite_pixel_blender rsp_check u_rsp_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_pixel    (out_pixel),
    .write_enable (write_enable)
);
